FILE: rtl/core/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared widths, operation codes, pipeline sizes, sideband record and
// rounding/saturation helpers of the quaternion ALU.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int CW   = 16;
  localparam int FB   = 14;
  localparam int SW   = 32;
  localparam int CMAX = (1 << (CW - 1)) - 1;

  localparam int PW   = 2 * CW;
  localparam int HW   = PW + 2;
  localparam int M2W  = PW + 1;

  localparam int SQ_PAIRS  = 32;
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = SQ_PAIRS / SQ_STEPS;
  localparam int SQ_RW     = 36;

  localparam int DIV_BITS   = CW + 2 * FB;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
  localparam int DIV_RW     = SW + 1;

  localparam int LATENCY = 3 + SQ_STAGES + DIV_STAGES + 1;

  localparam logic [2:0] FN_MUL  = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SCL  = 3'd2;
  localparam logic [2:0] FN_CONJ = 3'd3;
  localparam logic [2:0] FN_MAG2 = 3'd4;
  localparam logic [2:0] FN_MAG  = 3'd5;
  localparam logic [2:0] FN_NORM = 3'd6;

  typedef struct packed {
    logic [2:0]           func;
    logic [3:0][CW-1:0]   a;
    logic [3:0][CW-1:0]   r;
    logic [SW-1:0]        scal;
    logic                 ovf;
    logic                 m2z;
  } side_t;

  // round half up from 2*FB to FB fraction bits, then saturate; top bit is the flag
  function automatic logic [CW:0] rnd_sat(input logic signed [HW-1:0] v);
    logic signed [HW-1:0] t;
    t = (v + HW'(1 << (FB - 1))) >>> FB;
    if (t > HW'(CMAX))             rnd_sat = {1'b1, CW'(CMAX)};
    else if (t < -HW'(CMAX) - HW'(1)) rnd_sat = {1'b1, ~CW'(CMAX)};
    else                           rnd_sat = {1'b0, t[CW-1:0]};
  endfunction

  function automatic logic [CW:0] sat_c(input logic signed [CW:0] v);
    if (v > (CW+1)'(CMAX))                 sat_c = {1'b1, CW'(CMAX)};
    else if (v < -(CW+1)'(CMAX) - (CW+1)'(1)) sat_c = {1'b1, ~CW'(CMAX)};
    else                                   sat_c = {1'b0, v[CW-1:0]};
  endfunction

endpackage

FILE: rtl/core/qalu_arith.sv
// ----------------------------------------------------------------------------
// qalu_arith
// Three-stage front end: products, sums, rounding and saturation for
// multiply, add, scale, conjugate and squared magnitude.
// ----------------------------------------------------------------------------
module qalu_arith (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [2:0]                   in_func,
  input  logic [3:0][qalu_pkg::CW-1:0] in_a,
  input  logic [3:0][qalu_pkg::CW-1:0] in_b,
  input  logic [qalu_pkg::CW-1:0]      in_s,
  output logic                         out_vld,
  output qalu_pkg::side_t              out_side,
  output logic [qalu_pkg::M2W-1:0]     out_m2
);
  import qalu_pkg::*;

  logic signed [CW-1:0] a [4];
  logic signed [CW-1:0] b [4];
  logic signed [CW-1:0] s;

  logic                 vld1_r, vld2_r, vld3_r;
  logic [2:0]           func1_r, func2_r;
  logic [3:0][CW-1:0]   a1_r, a2_r;
  logic signed [PW-1:0] hp1_r [16];
  logic signed [PW-1:0] sq1_r [4];
  logic signed [PW-1:0] sp1_r [4];
  logic [3:0][CW:0]     ac1_r, ac2_r;
  logic signed [HW-1:0] hs2_r [4];
  logic signed [PW-1:0] sp2_r [4];
  logic [M2W-1:0]       m22_r, m23_r;
  side_t                side3_r, side3_nxt;

  logic signed [PW-1:0] hp_nxt [16];
  logic [3:0][CW:0]     ac_nxt;
  logic signed [HW-1:0] hs_nxt [4];
  logic [M2W-1:0]       m2_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = in_a[i];
      b[i] = in_b[i];
    end
    s = in_s;
  end

  always_comb begin
    hp_nxt[0]  = a[0] * b[0];  hp_nxt[1]  = a[1] * b[1];
    hp_nxt[2]  = a[2] * b[2];  hp_nxt[3]  = a[3] * b[3];
    hp_nxt[4]  = a[0] * b[1];  hp_nxt[5]  = b[0] * a[1];
    hp_nxt[6]  = a[2] * b[3];  hp_nxt[7]  = a[3] * b[2];
    hp_nxt[8]  = a[0] * b[2];  hp_nxt[9]  = b[0] * a[2];
    hp_nxt[10] = a[3] * b[1];  hp_nxt[11] = a[1] * b[3];
    hp_nxt[12] = a[0] * b[3];  hp_nxt[13] = b[0] * a[3];
    hp_nxt[14] = a[1] * b[2];  hp_nxt[15] = a[2] * b[1];
    for (int i = 0; i < 4; i++) begin
      if (in_func == FN_ADD) ac_nxt[i] = sat_c((CW+1)'(a[i]) + (CW+1)'(b[i]));
      else if (i == 0)       ac_nxt[i] = {1'b0, in_a[0]};
      else                   ac_nxt[i] = sat_c(-(CW+1)'(a[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    func1_r <= in_func;
    a1_r    <= in_a;
    ac1_r   <= ac_nxt;
    for (int i = 0; i < 16; i++) hp1_r[i] <= hp_nxt[i];
    for (int i = 0; i < 4; i++) begin
      sq1_r[i] <= a[i] * a[i];
      sp1_r[i] <= a[i] * s;
    end
  end

  always_comb begin
    hs_nxt[0] = HW'(hp1_r[0]) - HW'(hp1_r[1]) - HW'(hp1_r[2]) - HW'(hp1_r[3]);
    hs_nxt[1] = HW'(hp1_r[4]) + HW'(hp1_r[5]) + HW'(hp1_r[6]) - HW'(hp1_r[7]);
    hs_nxt[2] = HW'(hp1_r[8]) + HW'(hp1_r[9]) + HW'(hp1_r[10]) - HW'(hp1_r[11]);
    hs_nxt[3] = HW'(hp1_r[12]) + HW'(hp1_r[13]) + HW'(hp1_r[14]) - HW'(hp1_r[15]);
    m2_nxt = M2W'(unsigned'(sq1_r[0])) + M2W'(unsigned'(sq1_r[1]))
           + M2W'(unsigned'(sq1_r[2])) + M2W'(unsigned'(sq1_r[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    func2_r <= func1_r;
    a2_r    <= a1_r;
    ac2_r   <= ac1_r;
    m22_r   <= m2_nxt;
    for (int i = 0; i < 4; i++) begin
      hs2_r[i] <= hs_nxt[i];
      sp2_r[i] <= sp1_r[i];
    end
  end

  always_comb begin
    logic [CW:0] t;
    side3_nxt      = '0;
    side3_nxt.func = func2_r;
    side3_nxt.a    = a2_r;
    side3_nxt.m2z  = (m22_r == '0);
    t              = '0;
    for (int i = 0; i < 4; i++) begin
      case (func2_r)
        FN_MUL: begin
          t = rnd_sat(hs2_r[i]);
        end
        FN_SCL: begin
          t = rnd_sat(HW'(sp2_r[i]));
        end
        FN_ADD, FN_CONJ: begin
          t = ac2_r[i];
        end
        default: begin
          t = '0;
        end
      endcase
      side3_nxt.r[i] = t[CW-1:0];
      side3_nxt.ovf  = side3_nxt.ovf | t[CW];
    end
    if (func2_r == FN_MAG2) begin
      if (m22_r[M2W-1]) begin
        side3_nxt.scal = '1;
        side3_nxt.ovf  = 1'b1;
      end else begin
        side3_nxt.scal = m22_r[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    side3_r <= side3_nxt;
    m23_r   <= m22_r;
  end

  assign out_vld  = vld3_r;
  assign out_side = side3_r;
  assign out_m2   = m23_r;

endmodule

FILE: rtl/core/qalu_sqrt.sv
// ----------------------------------------------------------------------------
// qalu_sqrt
// Pipelined digit-by-digit square root of the squared magnitude, a fixed
// number of result bits per stage.
// ----------------------------------------------------------------------------
module qalu_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  qalu_pkg::side_t          in_side,
  input  logic [qalu_pkg::M2W-1:0] in_m2,
  output logic                     out_vld,
  output qalu_pkg::side_t          out_side,
  output logic [qalu_pkg::SW-1:0]  out_root
);
  import qalu_pkg::*;

  localparam int XW = 2 * SQ_PAIRS;

  logic              vld_p  [SQ_STAGES+1];
  side_t             side_p [SQ_STAGES+1];
  logic [XW-1:0]     x_p    [SQ_STAGES+1];
  logic [SQ_RW-1:0]  rem_p  [SQ_STAGES+1];
  logic [SW-1:0]     root_p [SQ_STAGES+1];

  always_comb begin
    vld_p[0]  = in_vld;
    side_p[0] = in_side;
    x_p[0]    = XW'({in_m2, (2 * FB)'(0)});
    rem_p[0]  = '0;
    root_p[0] = '0;
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [XW-1:0]    x_nxt;
    logic [SQ_RW-1:0] rem_nxt;
    logic [SW-1:0]    root_nxt;
    logic [SQ_RW-1:0] trial;

    always_comb begin
      x_nxt    = x_p[g];
      rem_nxt  = rem_p[g];
      root_nxt = root_p[g];
      trial    = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_nxt = {rem_nxt[SQ_RW-3:0], x_nxt[XW-1:XW-2]};
        x_nxt   = {x_nxt[XW-3:0], 2'b00};
        trial   = SQ_RW'({root_nxt, 2'b01});
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[SW-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[SW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_p[g+1] <= 1'b0;
      end else begin
        vld_p[g+1] <= vld_p[g];
      end
      side_p[g+1] <= side_p[g];
      x_p[g+1]    <= x_nxt;
      rem_p[g+1]  <= rem_nxt;
      root_p[g+1] <= root_nxt;
    end
  end

  assign out_vld  = vld_p[SQ_STAGES];
  assign out_side = side_p[SQ_STAGES];
  assign out_root = root_p[SQ_STAGES];

endmodule

FILE: rtl/core/qalu_div.sv
// ----------------------------------------------------------------------------
// qalu_div
// Four-lane pipelined restoring divider: |a| * 2^(2*FB) / magnitude,
// a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module qalu_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  qalu_pkg::side_t                        in_side,
  input  logic [qalu_pkg::SW-1:0]                in_root,
  output logic                                   out_vld,
  output qalu_pkg::side_t                        out_side,
  output logic [qalu_pkg::SW-1:0]                out_root,
  output logic [3:0][qalu_pkg::DIV_BITS-1:0]     out_quo,
  output logic [3:0][qalu_pkg::DIV_RW-1:0]       out_rem
);
  import qalu_pkg::*;

  logic                            vld_p  [DIV_STAGES+1];
  side_t                           side_p [DIV_STAGES+1];
  logic [SW-1:0]                   root_p [DIV_STAGES+1];
  logic [3:0][DIV_BITS-1:0]        dq_p   [DIV_STAGES+1];
  logic [3:0][DIV_RW-1:0]          rem_p  [DIV_STAGES+1];

  always_comb begin
    vld_p[0]  = in_vld;
    side_p[0] = in_side;
    root_p[0] = in_root;
    rem_p[0]  = '0;
    for (int l = 0; l < 4; l++) begin
      if (in_side.a[l][CW-1]) dq_p[0][l] = {-in_side.a[l], (2 * FB)'(0)};
      else                    dq_p[0][l] = {in_side.a[l], (2 * FB)'(0)};
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [3:0][DIV_BITS-1:0] dq_nxt;
    logic [3:0][DIV_RW-1:0]   rem_nxt;

    always_comb begin
      dq_nxt  = dq_p[g];
      rem_nxt = rem_p[g];
      for (int l = 0; l < 4; l++) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
          rem_nxt[l] = {rem_nxt[l][DIV_RW-2:0], dq_nxt[l][DIV_BITS-1]};
          if (rem_nxt[l] >= DIV_RW'(root_p[g])) begin
            rem_nxt[l] = rem_nxt[l] - DIV_RW'(root_p[g]);
            dq_nxt[l]  = {dq_nxt[l][DIV_BITS-2:0], 1'b1};
          end else begin
            dq_nxt[l]  = {dq_nxt[l][DIV_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_p[g+1] <= 1'b0;
      end else begin
        vld_p[g+1] <= vld_p[g];
      end
      side_p[g+1] <= side_p[g];
      root_p[g+1] <= root_p[g];
      dq_p[g+1]   <= dq_nxt;
      rem_p[g+1]  <= rem_nxt;
    end
  end

  assign out_vld  = vld_p[DIV_STAGES];
  assign out_side = side_p[DIV_STAGES];
  assign out_root = root_p[DIV_STAGES];
  assign out_quo  = dq_p[DIV_STAGES];
  assign out_rem  = rem_p[DIV_STAGES];

endmodule

FILE: rtl/core/quaternion_alu_core.sv
// ----------------------------------------------------------------------------
// quaternion_alu_core
// Fixed-point quaternion ALU: Hamilton product, sum, scale, conjugate,
// squared magnitude, magnitude and normalize, with saturation flags.
// ----------------------------------------------------------------------------
// Fully pipelined: busy is always low, so an item is taken on every cycle
// start is high. Each item gives exactly one result, marked by out_valid, in
// order; the latency is the same for every operation and is set by the three
// arithmetic stages, the eight square-root stages (four root bits each), the
// eleven divider stages (four quotient bits each) and the output register.
// The receiver cannot stall.
module quaternion_alu_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_func,
  input  logic [qalu_pkg::CW-1:0]     in_a_w,
  input  logic [qalu_pkg::CW-1:0]     in_a_x,
  input  logic [qalu_pkg::CW-1:0]     in_a_y,
  input  logic [qalu_pkg::CW-1:0]     in_a_z,
  input  logic [qalu_pkg::CW-1:0]     in_b_w,
  input  logic [qalu_pkg::CW-1:0]     in_b_x,
  input  logic [qalu_pkg::CW-1:0]     in_b_y,
  input  logic [qalu_pkg::CW-1:0]     in_b_z,
  input  logic [qalu_pkg::CW-1:0]     in_scale_factor,
  output logic                        out_valid,
  output logic [qalu_pkg::CW-1:0]     out_r_w,
  output logic [qalu_pkg::CW-1:0]     out_r_x,
  output logic [qalu_pkg::CW-1:0]     out_r_y,
  output logic [qalu_pkg::CW-1:0]     out_r_z,
  output logic [qalu_pkg::SW-1:0]     out_scalar_out,
  output logic                        out_overflow,
  output logic                        out_zero_norm
);
  import qalu_pkg::*;

  logic                     ar_vld, sq_vld, dv_vld;
  side_t                    ar_side, sq_side, mid_side, dv_side;
  logic [M2W-1:0]           ar_m2;
  logic [SW-1:0]            sq_root, dv_root;
  logic [3:0][DIV_BITS-1:0] dv_quo;
  logic [3:0][DIV_RW-1:0]   dv_rem;

  logic                     valid_r;
  logic [3:0][CW-1:0]       r_r, r_nxt;
  logic [SW-1:0]            scal_r, scal_nxt;
  logic                     ovf_r, ovf_nxt, zn_r, zn_nxt;

  assign busy = 1'b0;

  qalu_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_func  (in_func),
    .in_a     ({in_a_z, in_a_y, in_a_x, in_a_w}),
    .in_b     ({in_b_z, in_b_y, in_b_x, in_b_w}),
    .in_s     (in_scale_factor),
    .out_vld  (ar_vld),
    .out_side (ar_side),
    .out_m2   (ar_m2)
  );

  qalu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ar_vld),
    .in_side  (ar_side),
    .in_m2    (ar_m2),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  always_comb begin
    mid_side = sq_side;
    if (sq_side.func == FN_MAG) mid_side.scal = sq_root;
  end

  qalu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_side  (mid_side),
    .in_root  (sq_root),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_root (dv_root),
    .out_quo  (dv_quo),
    .out_rem  (dv_rem)
  );

  always_comb begin
    logic [DIV_BITS:0] q;
    logic              neg;
    r_nxt    = dv_side.r;
    scal_nxt = dv_side.scal;
    ovf_nxt  = dv_side.ovf;
    zn_nxt   = 1'b0;
    q        = '0;
    neg      = 1'b0;
    if (dv_side.func == FN_NORM) begin
      ovf_nxt = 1'b0;
      if (dv_side.m2z) begin
        r_nxt  = '0;
        zn_nxt = 1'b1;
      end else begin
        for (int l = 0; l < 4; l++) begin
          neg = dv_side.a[l][CW-1];
          q   = (DIV_BITS+1)'(dv_quo[l]);
          if ({dv_rem[l], 1'b0} >= (DIV_RW+1)'(dv_root)) q = q + (DIV_BITS+1)'(1);
          if (!neg && q > (DIV_BITS+1)'(CMAX)) begin
            r_nxt[l] = CW'(CMAX);
            ovf_nxt  = 1'b1;
          end else if (neg && q > (DIV_BITS+1)'(CMAX) + (DIV_BITS+1)'(1)) begin
            r_nxt[l] = ~CW'(CMAX);
            ovf_nxt  = 1'b1;
          end else if (neg) begin
            r_nxt[l] = -q[CW-1:0];
          end else begin
            r_nxt[l] = q[CW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      r_r     <= '0;
      scal_r  <= '0;
      ovf_r   <= 1'b0;
      zn_r    <= 1'b0;
    end else begin
      valid_r <= dv_vld;
      r_r     <= r_nxt;
      scal_r  <= scal_nxt;
      ovf_r   <= dv_vld & ovf_nxt;
      zn_r    <= dv_vld & zn_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_r_w        = r_r[0];
  assign out_r_x        = r_r[1];
  assign out_r_y        = r_r[2];
  assign out_r_z        = r_r[3];
  assign out_scalar_out = scal_r;
  assign out_overflow   = ovf_r;
  assign out_zero_norm  = zn_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("item lost in pipeline");

  a_zn_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_zero_norm |-> (out_valid && !out_overflow && out_r_w == '0 && out_r_x == '0
                       && out_r_y == '0 && out_r_z == '0 && out_scalar_out == '0))
    else $error("zero-norm result not clean");

  a_ovf_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow |-> out_valid)
    else $error("overflow flag without result");

endmodule

FILE: sim/quaternion_alu_checker.sv
// ----------------------------------------------------------------------------
// quaternion_alu_checker
// Watches the item and result channels of the quaternion ALU, computes the
// expected result of every accepted item in fixed point and compares each
// result field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module quaternion_alu_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [2:0]              in_func,
  input  logic [15:0]             in_a_w,
  input  logic [15:0]             in_a_x,
  input  logic [15:0]             in_a_y,
  input  logic [15:0]             in_a_z,
  input  logic [15:0]             in_b_w,
  input  logic [15:0]             in_b_x,
  input  logic [15:0]             in_b_y,
  input  logic [15:0]             in_b_z,
  input  logic [15:0]             in_scale_factor,
  input  logic                    out_valid,
  input  logic [15:0]             out_r_w,
  input  logic [15:0]             out_r_x,
  input  logic [15:0]             out_r_y,
  input  logic [15:0]             out_r_z,
  input  logic [31:0]             out_scalar_out,
  input  logic                    out_overflow,
  input  logic                    out_zero_norm,
  output int                      fail_count,
  output int                      pending
);
  import qalu_pkg::*;

  typedef struct {
    logic [15:0] r [4];
    logic [31:0] scal;
    logic        ovf;
    logic        zn;
  } qres_t;

  qres_t expected_q [$];
  bit    sat_hit;

  assign pending = expected_q.size();

  function automatic longint clip16(longint v);
    if (v > 32767) begin
      sat_hit = 1;
      return 32767;
    end
    if (v < -32768) begin
      sat_hit = 1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint round_q14(longint v);
    return clip16((v + 64'sd8192) >>> 14);
  endfunction

  function automatic longint unsigned int_root(longint unsigned m2);
    longint unsigned root, rem, pair, trial;
    root = 0;
    rem = 0;
    for (int i = 31 + 14 - 1; i >= 0; i--) begin
      pair = (i < 14) ? 0 : ((m2 >> (2 * (i - 14))) & 3);
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unit_comp(longint c, longint unsigned root);
    longint unsigned num, q, r;
    num = (c < 0) ? -c : c;
    q = num / root;
    r = num % root;
    for (int k = 0; k < 28; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= root) begin
        r -= root;
        q |= 1;
      end
    end
    if ((r << 1) >= root) q++;
    return clip16((c < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic qres_t quat_result(logic [2:0] fn, logic [15:0] a [4],
                                        logic [15:0] b [4], logic [15:0] sf);
    qres_t res;
    longint av [4], bv [4], rv [4], s;
    longint unsigned m2, root;
    sat_hit = 0;
    for (int k = 0; k < 4; k++) begin
      av[k] = longint'($signed(a[k]));
      bv[k] = longint'($signed(b[k]));
      rv[k] = 0;
    end
    s = longint'($signed(sf));
    m2 = av[0]*av[0] + av[1]*av[1] + av[2]*av[2] + av[3]*av[3];
    res.scal = 0;
    res.zn = 0;
    case (fn)
      FN_MUL: begin
        rv[0] = round_q14(av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2] - av[3]*bv[3]);
        rv[1] = round_q14(av[0]*bv[1] + bv[0]*av[1] + av[2]*bv[3] - av[3]*bv[2]);
        rv[2] = round_q14(av[0]*bv[2] + bv[0]*av[2] + av[3]*bv[1] - av[1]*bv[3]);
        rv[3] = round_q14(av[0]*bv[3] + bv[0]*av[3] + av[1]*bv[2] - av[2]*bv[1]);
      end
      FN_ADD: for (int k = 0; k < 4; k++) rv[k] = clip16(av[k] + bv[k]);
      FN_SCL: for (int k = 0; k < 4; k++) rv[k] = round_q14(av[k] * s);
      FN_CONJ: begin
        rv[0] = av[0];
        for (int k = 1; k < 4; k++) rv[k] = clip16(-av[k]);
      end
      FN_MAG2: begin
        if (m2 > 64'hFFFF_FFFF) begin
          res.scal = '1;
          sat_hit = 1;
        end else begin
          res.scal = m2[31:0];
        end
      end
      FN_MAG: begin
        root = int_root(m2);
        if (root > 64'hFFFF_FFFF) begin
          res.scal = '1;
          sat_hit = 1;
        end else begin
          res.scal = root[31:0];
        end
      end
      FN_NORM: begin
        if (m2 == 0) begin
          res.zn = 1;
        end else begin
          root = int_root(m2);
          for (int k = 0; k < 4; k++) rv[k] = unit_comp(av[k], root);
        end
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) res.r[k] = rv[k][15:0];
    res.ovf = sat_hit;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    qres_t want;
    logic [15:0] a [4], b [4];
    if (rst_n) begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no pending item");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("r_w", 32'(want.r[0]), 32'(out_r_w));
          check_field("r_x", 32'(want.r[1]), 32'(out_r_x));
          check_field("r_y", 32'(want.r[2]), 32'(out_r_y));
          check_field("r_z", 32'(want.r[3]), 32'(out_r_z));
          check_field("scalar_out", want.scal, out_scalar_out);
          check_field("overflow", 32'(want.ovf), 32'(out_overflow));
          check_field("zero_norm", 32'(want.zn), 32'(out_zero_norm));
        end
      end
      if (start && !busy) begin
        a = '{in_a_w, in_a_x, in_a_y, in_a_z};
        b = '{in_b_w, in_b_x, in_b_y, in_b_z};
        expected_q.push_back(quat_result(in_func, a, b, in_scale_factor));
      end
    end
  end
endmodule

FILE: sim/quaternion_alu_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_alu_core_tb
// Drives directed and random quaternion items into the ALU with random start
// gaps and lets the checker judge every result; prints the verdict.
// ----------------------------------------------------------------------------
module quaternion_alu_core_tb;
  import qalu_pkg::*;

  logic        clk, rst_n, start, busy, out_valid, out_overflow, out_zero_norm;
  logic [2:0]  in_func;
  logic [15:0] in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z;
  logic [15:0] in_scale_factor, out_r_w, out_r_x, out_r_y, out_r_z;
  logic [31:0] out_scalar_out;
  int          fail_count, pending, quiet_cycles;

  localparam int WATCHDOG = 2000;

  quaternion_alu_core uut (.*);
  quaternion_alu_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hC000;
      5: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [2:0] fn, logic [15:0] aw, logic [15:0] ax,
                           logic [15:0] ay, logic [15:0] az, logic [15:0] bw,
                           logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                           logic [15:0] sf);
    in_func = fn;
    {in_a_w, in_a_x, in_a_y, in_a_z} = {aw, ax, ay, az};
    {in_b_w, in_b_x, in_b_y, in_b_z} = {bw, bx, by, bz};
    in_scale_factor = sf;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_random(logic [2:0] fn);
    send_item(fn, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
              pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp());
  endtask

  task automatic idle_burst();
    start = 1'b0;
    repeat ($urandom_range(1, 7)) @(negedge clk);
  endtask

  initial begin
    start = 0;
    rst_n = 0;
    {in_func, in_a_w, in_a_x, in_a_y, in_a_z} = '0;
    {in_b_w, in_b_x, in_b_y, in_b_z, in_scale_factor} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int f = 0; f < 8; f++) begin
      send_item(3'(f), 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
      send_item(3'(f), 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    end
    send_item(FN_NORM, '0, '0, '0, '0, 16'h1234, '0, '0, '0, '0);
    send_item(FN_NORM, '0, '0, '0, 16'h0001, '0, '0, '0, '0, '0);
    send_item(FN_MUL, 16'h4000, '0, '0, '0, '0, 16'h4000, '0, '0, '0);
    send_item(FN_MUL, '0, 16'h4000, '0, '0, '0, '0, 16'h4000, '0, '0);
    send_item(FN_SCL, 16'h0001, 16'hFFFF, '0, '0, '0, '0, '0, '0, 16'h2000);
    send_item(FN_MAG, 16'h4000, '0, '0, '0, '0, '0, '0, '0, '0);
    start = 0;
    wait (pending == 0);
    @(negedge clk);

    for (int n = 0; n < 1100; n++) begin
      if (n == 550) begin
        start = 0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (n < 950 && $urandom_range(0, 3) == 0) idle_burst();
      send_random(3'($urandom_range(0, 7)));
    end
    start = 0;
    wait (pending == 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
